@@ src/wpch_pkg.sv @@
// Shared types and constants for the windowed photon-count histogram.
// Depends on nothing; wpch_ctrl, wpch_datapath and the top level import it.
package wpch_pkg;

    // Fixed field widths of the channels.
    localparam int BIN_W   = 6;
    localparam int FIELD_W = 32;

    // Window length after reset and the largest value of a 32-bit field.
    localparam logic [BIN_W-1:0]   WINDOW_RESET = 6'd30;
    localparam logic [FIELD_W-1:0] FIELD_MAX    = 32'hFFFF_FFFF;

    // Input mode codes.
    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_FINISH = 1'b1;

    typedef logic [BIN_W-1:0] bin_t;
    typedef logic [BIN_W-1:0] cfg_word_t;

    // One detector word.
    typedef struct packed {
        logic mode;
        logic photon_bit;
    } sample_t;

    // One readout word.
    typedef struct packed {
        bin_t               bin_index;
        logic [FIELD_W-1:0] window_tally;
        logic [FIELD_W-1:0] total_windows;
        bin_t               peak_bin;
        logic               last;
    } result_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPD_RD,
        ST_UPD_WR,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_OUT_RD,
        ST_OUT_LOAD,
        ST_OUT_WAIT
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take_sample;
        logic mem_read;
        logic mem_write;
        logic addr_bin;
        logic idx_clear;
        logic idx_inc;
        logic peak_clear;
        logic scan_cmp;
        logic out_load;
        logic clear_record;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic window_done;
        logic idx_at_end;
        logic out_valid;
        logic out_taken;
    } ctrl_status_t;

endpackage

@@ src/wpch_stream_if.sv @@
// Valid/ready channel carrying one payload word per handshake.
// Depends on nothing; the payload type is given at instantiation.
interface wpch_stream_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ src/wpch_ram.sv @@
// Generic single-port RAM with a registered read.
// Depends on nothing.
module wpch_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic                                 re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                     wdata,
    output logic [WIDTH-1:0]                     rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read share the one address.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;
endmodule

@@ src/wpch_ctrl.sv @@
// Controller state machine of the photon-count histogram.
// Depends on wpch_pkg; drives the datapath by command and reads its status.
module wpch_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_mode,
    output logic                   in_ready,
    input  wpch_pkg::ctrl_status_t status,
    output wpch_pkg::ctrl_cmd_t    cmd
);
    import wpch_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_mode == MODE_FINISH)
                    begin
                        state_next = ST_SCAN_RD;
                    end
                    else if (status.window_done)
                    begin
                        state_next = ST_UPD_RD;
                    end
                end
            end
            ST_UPD_RD:   state_next = ST_UPD_WR;
            ST_UPD_WR:   state_next = ST_IDLE;
            ST_SCAN_RD:  state_next = ST_SCAN_CMP;
            ST_SCAN_CMP: state_next = status.idx_at_end ? ST_OUT_RD : ST_SCAN_RD;
            ST_OUT_RD:   state_next = ST_OUT_LOAD;
            ST_OUT_LOAD: state_next = ST_OUT_WAIT;
            ST_OUT_WAIT:
            begin
                if (status.out_taken)
                begin
                    state_next = status.idx_at_end ? ST_IDLE : ST_OUT_RD;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Commands for the current state.
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_mode == MODE_FINISH)
                    begin
                        cmd.idx_clear  = 1'b1;
                        cmd.peak_clear = 1'b1;
                    end
                    else
                    begin
                        cmd.take_sample = 1'b1;
                    end
                end
            end
            ST_UPD_RD:
            begin
                cmd.mem_read = 1'b1;
                cmd.addr_bin = 1'b1;
            end
            ST_UPD_WR:
            begin
                cmd.mem_write = 1'b1;
                cmd.addr_bin  = 1'b1;
            end
            ST_SCAN_RD:
            begin
                cmd.mem_read = 1'b1;
            end
            ST_SCAN_CMP:
            begin
                cmd.scan_cmp = 1'b1;
                if (status.idx_at_end)
                begin
                    cmd.idx_clear = 1'b1;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_OUT_RD:
            begin
                cmd.mem_read = 1'b1;
            end
            ST_OUT_LOAD:
            begin
                cmd.out_load = 1'b1;
            end
            ST_OUT_WAIT:
            begin
                if (status.out_taken)
                begin
                    if (status.idx_at_end)
                    begin
                        cmd.clear_record = 1'b1;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                    end
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // The write of a histogram update always follows its read.
    a_upd_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_UPD_WR |-> $past(state_reg) == ST_UPD_RD)
        else $error("histogram write without preceding read");

    // While waiting for the receiver a result is on offer.
    a_wait_valid: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_OUT_WAIT |-> status.out_valid)
        else $error("waiting for receiver with no result offered");

    // Taking the final bin ends the readout.
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        status.out_taken && status.idx_at_end |=> state_reg == ST_IDLE)
        else $error("readout did not end after the final bin");
endmodule

@@ src/wpch_datapath.sv @@
// Datapath of the photon-count histogram: window counters, histogram RAM,
// peak search and result register. Depends on wpch_pkg and wpch_ram.
module wpch_datapath #(
    parameter int MAX_WINDOW = 63,
    parameter int TALLY_BITS = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  wpch_pkg::ctrl_cmd_t    cmd,
    output wpch_pkg::ctrl_status_t status,
    input  logic                   photon_bit,
    input  logic                   cfg_write,
    input  wpch_pkg::cfg_word_t    cfg_data,
    input  logic                   out_ready,
    output logic                   out_valid,
    output wpch_pkg::result_t      result
);
    import wpch_pkg::*;

    localparam int DEPTH  = MAX_WINDOW + 1;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    bin_t                  window_length_reg;
    bin_t                  slot_reg;
    bin_t                  ones_reg;
    bin_t                  bin_reg;
    bin_t                  idx_reg;
    bin_t                  peak_reg;
    logic [TALLY_BITS-1:0] best_tally_reg;
    logic [FIELD_W-1:0]    total_reg;
    logic [DEPTH-1:0]      hist_valid_reg;
    result_t               result_reg;
    logic                  out_valid_reg;

    bin_t                  len_eff;
    bin_t                  slot_plus;
    bin_t                  ones_next;
    logic                  window_done;
    logic                  idx_at_end;
    logic                  out_taken;
    logic [ADDR_W-1:0]     mem_addr;
    logic [TALLY_BITS-1:0] mem_rdata;
    logic [TALLY_BITS-1:0] tally_cur;
    logic [TALLY_BITS-1:0] tally_inc;
    logic [FIELD_W-1:0]    tally_field;

    // Length in force: zero counts as one, long values are clamped.
    always_comb
    begin
        if (window_length_reg == '0)
        begin
            len_eff = 6'd1;
        end
        else if (window_length_reg > BIN_W'(MAX_WINDOW))
        begin
            len_eff = BIN_W'(MAX_WINDOW);
        end
        else
        begin
            len_eff = window_length_reg;
        end
    end

    // Window counting for the current sample.
    assign slot_plus   = slot_reg + 6'd1;
    assign ones_next   = ones_reg + BIN_W'(photon_bit);
    assign window_done = slot_plus >= len_eff;
    assign idx_at_end  = idx_reg == len_eff;
    assign out_taken   = out_valid_reg && out_ready;

    // Histogram RAM addressed by the finished window's bin or the walk index.
    assign mem_addr = cmd.addr_bin ? bin_reg[ADDR_W-1:0] : idx_reg[ADDR_W-1:0];

    // A bin that was never written since the last clear reads as zero.
    assign tally_cur = hist_valid_reg[mem_addr] ? mem_rdata : '0;
    assign tally_inc = (tally_cur == '1) ? tally_cur : tally_cur + TALLY_BITS'(1);
    assign tally_field = (tally_cur > TALLY_BITS'(FIELD_MAX)) ? FIELD_MAX
                                                              : FIELD_W'(tally_cur);

    wpch_ram #(
        .WIDTH (TALLY_BITS),
        .DEPTH (DEPTH)
    ) u_hist_ram (
        .clk   (clk),
        .we    (cmd.mem_write),
        .re    (cmd.mem_read),
        .addr  (mem_addr),
        .wdata (tally_inc),
        .rdata (mem_rdata)
    );

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= WINDOW_RESET;
        end
        else if (cfg_write)
        begin
            window_length_reg <= cfg_data;
        end
    end

    // Window position, photon count, window total and bin valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg       <= '0;
            ones_reg       <= '0;
            total_reg      <= '0;
            hist_valid_reg <= '0;
        end
        else if (cmd.clear_record)
        begin
            slot_reg       <= '0;
            ones_reg       <= '0;
            total_reg      <= '0;
            hist_valid_reg <= '0;
        end
        else
        begin
            if (cmd.take_sample)
            begin
                if (window_done)
                begin
                    slot_reg <= '0;
                    ones_reg <= '0;
                    if (total_reg != FIELD_MAX)
                    begin
                        total_reg <= total_reg + 32'd1;
                    end
                end
                else
                begin
                    slot_reg <= slot_plus;
                    ones_reg <= ones_next;
                end
            end
            if (cmd.mem_write)
            begin
                hist_valid_reg[mem_addr] <= 1'b1;
            end
        end
    end

    // Bin of the window just completed.
    always_ff @(posedge clk)
    begin
        if (cmd.take_sample && window_done)
        begin
            bin_reg <= ones_next;
        end
    end

    // Walk index and running peak over bins zero to the window length.
    always_ff @(posedge clk)
    begin
        if (cmd.idx_clear)
        begin
            idx_reg <= '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_reg <= idx_reg + 6'd1;
        end

        if (cmd.peak_clear)
        begin
            best_tally_reg <= '0;
            peak_reg       <= '0;
        end
        else if (cmd.scan_cmp && (tally_cur > best_tally_reg))
        begin
            best_tally_reg <= tally_cur;
            peak_reg       <= idx_reg;
        end
    end

    // Result register; it holds its word until the receiver takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_taken)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            result_reg.bin_index     <= idx_reg;
            result_reg.window_tally  <= tally_field;
            result_reg.total_windows <= total_reg;
            result_reg.peak_bin      <= peak_reg;
            result_reg.last          <= idx_at_end;
        end
    end

    assign out_valid          = out_valid_reg;
    assign result             = result_reg;
    assign status.window_done = window_done;
    assign status.idx_at_end  = idx_at_end;
    assign status.out_valid   = out_valid_reg;
    assign status.out_taken   = out_taken;

    // A completed window never selects a bin beyond the RAM.
    a_bin_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take_sample && window_done |-> ones_next <= BIN_W'(MAX_WINDOW))
        else $error("window bin outside histogram");

    // Clearing the record empties the histogram and the window count.
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_record |=> total_reg == '0 && hist_valid_reg == '0 && slot_reg == '0)
        else $error("record not cleared");
endmodule

@@ src/windowed_photon_count_histogram.sv @@
// Top level of the windowed photon-count histogram.
// Depends on wpch_pkg, wpch_stream_if, wpch_ctrl and wpch_datapath.
//
// Channels: samples (sink, sample_t words), results (source, result_t words)
// and cfg (sink, a 6-bit window length, always ready). A word moves at a
// rising edge of clk where valid and ready are both high.
// A sample word that does not complete a window leaves the block ready for
// the next word. One that completes a window passes through ST_UPD_RD and
// ST_UPD_WR: the bin's tally is read, incremented with saturation and
// written back through the single port of the histogram RAM. A finish word
// first walks bins 0 to L (L the window length in force) to find the peak,
// reading and comparing each bin, then reads each bin out through ST_OUT_RD,
// ST_OUT_LOAD and ST_OUT_WAIT, plus any time the receiver holds ready low.
// No new sample is taken until the final result is taken; that clears the record.
// While the receiver stalls, the result register holds its word unchanged.
// Reset (rst_n, asynchronous, active low) sets the window length to 30,
// empties the histogram at once through per-bin valid bits and clears the
// window position, photon count and window total.
module windowed_photon_count_histogram #(
    parameter int MAX_WINDOW = 63,
    parameter int TALLY_BITS = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    wpch_stream_if.sink   samples,
    wpch_stream_if.source results,
    wpch_stream_if.sink   cfg
);
    import wpch_pkg::*;

    ctrl_cmd_t    cmd;
    ctrl_status_t status;
    sample_t      sample_word;
    cfg_word_t    cfg_word;
    result_t      result_word;
    logic         in_ready;
    logic         out_valid;

    assign sample_word = samples.payload;
    assign cfg_word    = cfg.payload;

    // Configuration is always taken.
    assign cfg.ready = 1'b1;

    wpch_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .in_mode  (sample_word.mode),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    wpch_datapath #(
        .MAX_WINDOW (MAX_WINDOW),
        .TALLY_BITS (TALLY_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .photon_bit (sample_word.photon_bit),
        .cfg_write  (cfg.valid && cfg.ready),
        .cfg_data   (cfg_word),
        .out_ready  (results.ready),
        .out_valid  (out_valid),
        .result     (result_word)
    );

    assign samples.ready   = in_ready;
    assign results.valid   = out_valid;
    assign results.payload = result_word;
endmodule
